/* rtl/ffba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator package
// Shared status codes and the command and status structs that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic [2:0] ST_ALLOCATED  = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_FIT     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_FREED      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

  // Commands from the controller to the table datapath.
  typedef struct packed {
    logic load;      // capture the request fields
    logic clr_idx;   // restart the table walk at entry 0
    logic inc_idx;   // step the walk to the next entry
    logic shift_up;  // open a hole at idx+1 for a split remainder
    logic split;     // write the split and the allocated entry
    logic take;      // allocate the current entry whole
    logic release_e; // free the current entry if the owner matches
    logic merge;     // fold entry idx+1 into entry idx and close the gap
  } ffba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;   // request is a free
    logic bad_size;  // request size is zero or too large
    logic in_range;  // walk index is below the block count
    logic pair_ok;   // idx+1 is below the block count
    logic fits;      // current entry is free and large enough
    logic exact;     // current entry has exactly the requested size
    logic full;      // table holds the maximum number of entries
    logic owned;     // current entry is allocated to the request owner
    logic both_free; // entries idx and idx+1 are both free
    logic shift_done;// hole has reached idx+1
  } ffba_stat_t;

endpackage

/* rtl/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit block allocator
// Address-ordered block table with first-fit allocation and coalescing free.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate walks the table one entry per
// cycle until the first free block that is large enough; a split then moves
// the later entries up one per cycle. A free walks every entry once to release
// the owner's blocks and then walks again, merging one neighbor pair per
// cycle. Each result is held in a register until taken; the next item is
// accepted in the cycle after that result has left.
module first_fit_block_allocator #(
  parameter int MEM_BYTES  = 4096,
  parameter int MAX_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // action[0], owner_id[8:1], request_size[21:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // status[2:0], address[14:3]
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;
  logic [11:0] cur_addr;
  logic [2:0]  res_status;
  logic [11:0] res_addr;
  logic        in_fire;

  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = {1'b0, res_addr, res_status};

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_status(res_status),
    .out_addr  (res_addr),
    .stat      (stat),
    .cur_addr  (cur_addr),
    .cmd       (cmd)
  );

  ffba_table #(
    .MEM_BYTES (MEM_BYTES),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .owner_in (s_tdata[8:1]),
    .size_in  (s_tdata[21:9]),
    .action_in(s_tdata[0]),
    .stat     (stat),
    .cur_addr (cur_addr)
  );

endmodule

/* rtl/ffba_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator table datapath
// Holds the block table and walk index and carries out single-entry steps.
// ----------------------------------------------------------------------------
module ffba_table #(
  parameter int MEM_BYTES  = 4096,
  parameter int MAX_BLOCKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ffba_pkg::ffba_cmd_t cmd,
  input  logic [7:0]        owner_in,
  input  logic [12:0]       size_in,
  input  logic              action_in,
  output ffba_pkg::ffba_stat_t stat,
  output logic [11:0]       cur_addr
);
  import ffba_pkg::*;

  localparam int AW = $clog2(MEM_BYTES + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [AW-1:0] start_q [MAX_BLOCKS];
  logic [AW-1:0] len_q   [MAX_BLOCKS];
  logic [7:0]    own_q   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] free_q;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] hole;
  logic [7:0]    owner;
  logic [AW-1:0] size;
  logic          action;
  logic          size_bad;

  logic [IW-1:0] i0, i1, hm1;
  logic [CW-1:0] idx1;

  assign idx1 = idx + CW'(1);
  assign i0   = idx[IW-1:0];
  assign i1   = idx1[IW-1:0];
  assign hm1  = IW'(hole - CW'(1));

  assign stat.is_free    = action;
  assign stat.bad_size   = size_bad;
  assign stat.in_range   = (idx < count);
  assign stat.pair_ok    = (idx1 < count);
  assign stat.fits       = free_q[i0] && (len_q[i0] >= size);
  assign stat.exact      = (len_q[i0] == size);
  assign stat.full       = (count == CW'(MAX_BLOCKS));
  assign stat.owned      = !free_q[i0] && (own_q[i0] == owner);
  assign stat.both_free  = free_q[i0] && free_q[i1];
  assign stat.shift_done = (hole == idx1);
  assign cur_addr        = 12'(start_q[i0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      owner    <= owner_in;
      action   <= action_in;
      size     <= AW'(size_in);
      size_bad <= (size_in == 13'd0) || (32'(size_in) > 32'(MEM_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= CW'(1);
      idx    <= '0;
      hole   <= '0;
      free_q <= MAX_BLOCKS'(1);
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        start_q[k] <= '0;
        len_q[k]   <= '0;
        own_q[k]   <= '0;
      end
      len_q[0] <= AW'(MEM_BYTES);
    end else begin
      if (cmd.clr_idx) begin
        idx  <= '0;
        hole <= count;
      end
      if (cmd.inc_idx) idx <= idx1;
      if (cmd.shift_up) begin
        // Move one entry up per cycle, from the top toward idx+1.
        start_q[hole[IW-1:0]] <= start_q[hm1];
        len_q[hole[IW-1:0]]   <= len_q[hm1];
        own_q[hole[IW-1:0]]   <= own_q[hm1];
        free_q[hole[IW-1:0]]  <= free_q[hm1];
        hole <= hole - CW'(1);
      end
      if (cmd.split) begin
        start_q[i1] <= start_q[i0] + size;
        len_q[i1]   <= len_q[i0] - size;
        own_q[i1]   <= '0;
        free_q[i1]  <= 1'b1;
        count       <= count + CW'(1);
      end
      if (cmd.split || cmd.take) begin
        len_q[i0]  <= size;
        own_q[i0]  <= owner;
        free_q[i0] <= 1'b0;
      end
      if (cmd.release_e) begin
        free_q[i0] <= 1'b1;
        own_q[i0]  <= '0;
      end
      if (cmd.merge) begin
        len_q[i0] <= len_q[i0] + len_q[i1];
        for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
          if (CW'(k) > idx) begin
            start_q[k] <= start_q[k+1];
            len_q[k]   <= len_q[k+1];
            own_q[k]   <= own_q[k+1];
            free_q[k]  <= free_q[k+1];
          end
        end
        start_q[MAX_BLOCKS-1] <= '0;
        len_q[MAX_BLOCKS-1]   <= '0;
        own_q[MAX_BLOCKS-1]   <= '0;
        free_q[MAX_BLOCKS-1]  <= 1'b0;
        count <= count - CW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(1)) && (count <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");
  a_split_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.split |=> count == $past(count) + CW'(1))
    else $error("split did not grow the table");
  a_merge_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |=> count == $past(count) - CW'(1))
    else $error("merge did not shrink the table");

endmodule

/* rtl/ffba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the table walks for allocate and free requests.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [11:0]          out_addr,
  input  ffba_pkg::ffba_stat_t stat,
  input  logic [11:0]          cur_addr,
  output ffba_pkg::ffba_cmd_t  cmd
);
  import ffba_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_REL   = 7'b0010000,
    S_MERGE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic found, found_next;
  logic [2:0] res_status, res_status_next;
  logic [11:0] res_addr, res_addr_next;

  assign in_ready   = (state == S_IDLE) && !out_valid;
  assign out_status = res_status;
  assign out_addr   = res_addr;

  always_comb begin
    state_next      = state;
    found_next      = found;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clr_idx   = 1'b1;
        found_next    = 1'b0;
        res_addr_next = '0;
        if (stat.is_free) begin
          state_next = S_REL;
        end else if (stat.bad_size) begin
          res_status_next = ST_BAD_SIZE;
          state_next      = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.in_range) begin
          res_status_next = ST_NO_FIT;
          state_next      = S_DONE;
        end else if (!stat.fits) begin
          cmd.inc_idx = 1'b1;
        end else if (stat.exact) begin
          cmd.take        = 1'b1;
          res_status_next = ST_ALLOCATED;
          res_addr_next   = cur_addr;
          state_next      = S_DONE;
        end else if (stat.full) begin
          res_status_next = ST_TABLE_FULL;
          state_next      = S_DONE;
        end else if (stat.shift_done) begin
          cmd.split       = 1'b1;
          res_status_next = ST_ALLOCATED;
          res_addr_next   = cur_addr;
          state_next      = S_DONE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = S_SCAN;
        end else begin
          cmd.shift_up = 1'b1;
        end
      end
      S_REL: begin
        if (stat.in_range) begin
          cmd.release_e = 1'b1;
          cmd.inc_idx   = 1'b1;
          if (stat.owned) found_next = 1'b1;
        end else if (!found) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          cmd.clr_idx = 1'b1;
          state_next  = S_MERGE;
        end
      end
      S_MERGE: begin
        if (!stat.pair_ok) begin
          res_status_next = ST_FREED;
          state_next      = S_DONE;
        end else if (stat.both_free) begin
          cmd.merge = 1'b1;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // release_e only acts on an owned entry.
    if (state == S_REL && !stat.owned) cmd.release_e = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == S_IDLE && !out_valid)
    else $error("item accepted while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid)
    else $error("result not presented");

endmodule
